[rtl/srtd_pkg.sv]
// Shared types and constants of the signed run transient detector.
// Used by every module of the block except srtd_fifo; depends on nothing.
`default_nettype none

package srtd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  localparam int INDEX_W = 16;
  localparam int LEN_W   = 17;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 8;
  localparam int AVG_W   = 16;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W  = AVG_W + LEN_W;
  localparam int STAT_W  = 2;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AVERAGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LIMIT   = 2'd2;

  localparam logic [LEN_W-1:0] MIN_RUN_LEN_RST = 17'd1;
  localparam logic [AVG_W-1:0] MIN_AVERAGE_RST = 16'd0;
  localparam logic [CNT_W-1:0] RUN_LIMIT_RST   = 8'd8;

  localparam logic [STAT_W-1:0] ST_FOUND   = 2'd0;
  localparam logic [STAT_W-1:0] ST_TOO_FEW = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE    = 2'd2;

  localparam int EVQ_DEPTH = 4;
  localparam int RSQ_DEPTH = 2;

  typedef struct packed {
    logic [LEN_W-1:0] min_run_len;
    logic [AVG_W-1:0] min_average;
    logic [CNT_W-1:0] run_limit;
  } cfg_t;

  typedef struct packed {
    logic [INDEX_W-1:0] first;
    logic [LEN_W-1:0]   len;
    logic               positive;
    logic [SUM_W-1:0]   sum;
  } run_t;

  typedef struct packed {
    logic               has_run;
    run_t               run;
    logic               has_tail;
    logic               tail_positive;
    logic [INDEX_W-1:0] tail_first;
    logic [SUM_W-1:0]   tail_mag;
    logic               last;
    logic               too_few;
  } event_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    run_t              run;
  } result_t;

endpackage

`default_nettype wire

[rtl/srtd_fifo.sv]
// Small first-in first-out queue of packed items.
// Generic; used between the front and back parts and on the result side.
`default_nettype none

module srtd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    full    = (count_r == CNT_W'(DEPTH));
    empty   = (count_r == '0);
    do_push = push & ~full;
    do_pop  = pop & ~empty;
    rdata   = mem[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/srtd_front.sv]
// Front part: accepts samples, tracks the open run and emits run-close and end-of-trace events.
// Depends on srtd_pkg.
`default_nettype none

module srtd_front #(
  parameter int SAMPLE_BITS = srtd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire srtd_pkg::cfg_t                cfg,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_last,
  output logic                               ev_push,
  output srtd_pkg::event_t                   ev,
  input  wire logic                          ev_full
);

  localparam int INDEX_W = srtd_pkg::INDEX_W;
  localparam int LEN_W   = srtd_pkg::LEN_W;
  localparam int SUM_W   = srtd_pkg::SUM_W;
  localparam int CNT_W   = srtd_pkg::CNT_W;

  logic [INDEX_W-1:0] idx_r, idx_nxt;
  logic               cur_pos_r, cur_pos_nxt;
  logic [INDEX_W-1:0] cur_first_r, cur_first_nxt;
  logic [LEN_W-1:0]   cur_len_r, cur_len_nxt;
  logic [SUM_W-1:0]   cur_sum_r, cur_sum_nxt;
  logic [CNT_W-1:0]   closed_r, closed_nxt;
  logic               stopped_r, stopped_nxt;

  logic                   accept;
  logic                   pos;
  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SUM_W-1:0]       mag_w;
  logic [SUM_W:0]         sum_ext;
  logic [SUM_W-1:0]       sum_acc;
  logic [LEN_W-1:0]       len_acc;
  logic [CNT_W-1:0]       limit_eff;
  logic [CNT_W-1:0]       closed_a, closed_b;
  logic                   live, cur_open, close_a, close_b, stop_a;

  always_comb begin
    accept    = push & ~ev_full;
    full      = ev_full;
    raw       = in_sample;
    pos       = ~raw[SAMPLE_BITS-1];
    mag       = pos ? raw : (~raw + 1'b1);
    mag_w     = SUM_W'(mag);
    limit_eff = (cfg.run_limit == '0) ? CNT_W'(1) : cfg.run_limit;

    live     = ~stopped_r;
    cur_open = (cur_len_r != '0);
    close_a  = live && cur_open && (pos != cur_pos_r);
    closed_a = closed_r + CNT_W'(close_a);
    stop_a   = stopped_r | (close_a && (closed_a >= limit_eff));

    sum_ext = {1'b0, cur_sum_r} + {1'b0, mag_w};
    sum_acc = sum_ext[SUM_W] ? srtd_pkg::SUM_MAX : sum_ext[SUM_W-1:0];
    len_acc = (cur_len_r == srtd_pkg::LEN_MAX) ? cur_len_r : cur_len_r + 1'b1;

    cur_pos_nxt   = cur_pos_r;
    cur_first_nxt = cur_first_r;
    cur_len_nxt   = cur_len_r;
    cur_sum_nxt   = cur_sum_r;
    if (live && !stop_a) begin
      if (!cur_open || close_a) begin
        cur_pos_nxt   = pos;
        cur_first_nxt = idx_r;
        cur_len_nxt   = LEN_W'(1);
        cur_sum_nxt   = mag_w;
      end else begin
        cur_len_nxt = len_acc;
        cur_sum_nxt = sum_acc;
      end
    end

    close_b  = in_last && !stop_a;
    closed_b = closed_a + CNT_W'(close_b);

    ev.has_run = close_a || close_b;
    if (close_a) begin
      ev.run.first    = cur_first_r;
      ev.run.len      = cur_len_r;
      ev.run.positive = cur_pos_r;
      ev.run.sum      = cur_sum_r;
    end else begin
      ev.run.first    = cur_first_nxt;
      ev.run.len      = cur_len_nxt;
      ev.run.positive = cur_pos_nxt;
      ev.run.sum      = cur_sum_nxt;
    end
    ev.has_tail      = close_a && close_b;
    ev.tail_positive = pos;
    ev.tail_first    = idx_r;
    ev.tail_mag      = mag_w;
    ev.last          = in_last;
    ev.too_few       = (closed_b < limit_eff);
    ev_push          = accept && (close_a || in_last);

    idx_nxt     = idx_r + 1'b1;
    closed_nxt  = closed_a;
    stopped_nxt = stop_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cur_pos_r   <= 1'b0;
      cur_first_r <= '0;
      cur_len_r   <= '0;
      cur_sum_r   <= '0;
      closed_r    <= '0;
      stopped_r   <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        idx_r       <= '0;
        cur_pos_r   <= 1'b0;
        cur_first_r <= '0;
        cur_len_r   <= '0;
        cur_sum_r   <= '0;
        closed_r    <= '0;
        stopped_r   <= 1'b0;
      end else begin
        idx_r       <= idx_nxt;
        cur_pos_r   <= cur_pos_nxt;
        cur_first_r <= cur_first_nxt;
        cur_len_r   <= cur_len_nxt;
        cur_sum_r   <= cur_sum_nxt;
        closed_r    <= closed_nxt;
        stopped_r   <= stopped_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/srtd_back.sv]
// Back part: tests closed runs against the thresholds, keeps the first match
// and builds the result at the end of a trace. Depends on srtd_pkg.
`default_nettype none

module srtd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire srtd_pkg::cfg_t    cfg,
  input  wire logic              ev_valid,
  input  wire srtd_pkg::event_t  ev,
  output logic                   ev_pop,
  output logic                   res_push,
  output srtd_pkg::result_t      res,
  input  wire logic              res_full
);

  localparam int LEN_W  = srtd_pkg::LEN_W;
  localparam int SUM_W  = srtd_pkg::SUM_W;
  localparam int PROD_W = srtd_pkg::PROD_W;

  logic              s1_valid_r, s1_valid_nxt;
  srtd_pkg::event_t  s1_ev_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_c;

  logic              found_r, found_nxt;
  srtd_pkg::run_t    best_r, best_nxt;

  logic              s1_adv, s1_load;
  logic              pass_m, pass_t;
  srtd_pkg::run_t    tail_run;

  always_comb begin
    prod_c = ev.run.len * cfg.min_average;

    s1_adv       = s1_valid_r && (!s1_ev_r.last || !res_full);
    s1_load      = ev_valid && (!s1_valid_r || s1_adv);
    ev_pop       = s1_load;
    s1_valid_nxt = s1_load ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

    pass_m = s1_ev_r.has_run
          && (s1_ev_r.run.len >= cfg.min_run_len)
          && ({1'b0, s1_ev_r.run.sum} >= prod_r);
    pass_t = s1_ev_r.has_tail
          && (cfg.min_run_len <= LEN_W'(1))
          && (s1_ev_r.tail_mag >= SUM_W'(cfg.min_average));

    tail_run.first    = s1_ev_r.tail_first;
    tail_run.len      = LEN_W'(1);
    tail_run.positive = s1_ev_r.tail_positive;
    tail_run.sum      = s1_ev_r.tail_mag;

    found_nxt = found_r;
    best_nxt  = best_r;
    if (!found_r && pass_m) begin
      found_nxt = 1'b1;
      best_nxt  = s1_ev_r.run;
    end else if (!found_r && pass_t) begin
      found_nxt = 1'b1;
      best_nxt  = tail_run;
    end

    res_push = s1_adv && s1_ev_r.last;
    res.run  = '0;
    if (s1_ev_r.too_few) begin
      res.status = srtd_pkg::ST_TOO_FEW;
    end else if (found_nxt) begin
      res.status = srtd_pkg::ST_FOUND;
      res.run    = best_nxt;
    end else begin
      res.status = srtd_pkg::ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_adv) begin
        found_r <= s1_ev_r.last ? 1'b0 : found_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_ev_r <= ev;
      prod_r  <= prod_c;
    end
    if (s1_adv) begin
      best_r <= best_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/signed_run_transient_detector.sv]
// Top level of the signed run transient detector: configuration registers,
// front part, event queue, back part and result queue. Depends on srtd_pkg.
//
// Usage:
//   Samples enter on the input queue port: an item is taken at a clock edge
//   with push high and full low. in_last marks the final sample of a trace.
//   One result per trace leaves on the result queue port: while empty is low
//   the oldest result is shown, and it is taken at an edge with pop high.
//   Throughput is one sample per cycle while full is low; the front part
//   updates the open run in the cycle a sample is taken and writes a close
//   event to a 4-entry queue. The back part registers the threshold product,
//   then tests the run. When pop stays low, results wait in a 2-entry queue;
//   once it fills, the back part holds, the event queue fills and full rises.
//   Configuration writes take effect at the next edge; the user must see that
//   they are made only between traces, which the block does not enforce.
//   Reset (rst_n low, synchronous) empties both queues, clears the trace
//   state and restores min_run_len 1, min_average 0, run_limit 8.
`default_nettype none

module signed_run_transient_detector #(
  parameter int SAMPLE_BITS = srtd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  wire logic                                  in_last,
  output logic                                       empty,
  input  wire logic                                  pop,
  output logic [srtd_pkg::STAT_W-1:0]                out_status,
  output logic [srtd_pkg::INDEX_W-1:0]               out_run_first,
  output logic [srtd_pkg::LEN_W-1:0]                 out_run_len,
  output logic                                       out_run_positive,
  output logic [srtd_pkg::SUM_W-1:0]                 out_run_sum,
  input  wire logic                                  cfg_we,
  input  wire logic [srtd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [srtd_pkg::CFG_W-1:0]            cfg_wdata
);

  srtd_pkg::cfg_t    cfg_r;
  logic              ev_push, ev_full, ev_empty, ev_pop;
  srtd_pkg::event_t  ev_in, ev_head;
  logic              res_push, res_full;
  srtd_pkg::result_t res_in, res_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_run_len <= srtd_pkg::MIN_RUN_LEN_RST;
      cfg_r.min_average <= srtd_pkg::MIN_AVERAGE_RST;
      cfg_r.run_limit   <= srtd_pkg::RUN_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        srtd_pkg::REG_MIN_RUN_LEN: cfg_r.min_run_len <= cfg_wdata;
        srtd_pkg::REG_MIN_AVERAGE: cfg_r.min_average <= cfg_wdata[srtd_pkg::AVG_W-1:0];
        srtd_pkg::REG_RUN_LIMIT:   cfg_r.run_limit   <= cfg_wdata[srtd_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  srtd_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .push      (push),
    .full      (full),
    .in_sample (in_sample),
    .in_last   (in_last),
    .ev_push   (ev_push),
    .ev        (ev_in),
    .ev_full   (ev_full)
  );

  srtd_fifo #(
    .WIDTH ($bits(srtd_pkg::event_t)),
    .DEPTH (srtd_pkg::EVQ_DEPTH)
  ) u_evq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ev_push),
    .wdata (ev_in),
    .full  (ev_full),
    .pop   (ev_pop),
    .rdata (ev_head),
    .empty (ev_empty)
  );

  srtd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .ev_valid (~ev_empty),
    .ev       (ev_head),
    .ev_pop   (ev_pop),
    .res_push (res_push),
    .res      (res_in),
    .res_full (res_full)
  );

  srtd_fifo #(
    .WIDTH ($bits(srtd_pkg::result_t)),
    .DEPTH (srtd_pkg::RSQ_DEPTH)
  ) u_rsq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  always_comb begin
    out_status       = res_head.status;
    out_run_first    = res_head.run.first;
    out_run_len      = res_head.run.len;
    out_run_positive = res_head.run.positive;
    out_run_sum      = res_head.run.sum;
  end

endmodule

`default_nettype wire

[rtl/srtd_check.sv]
// Port-level checks of the signed run transient detector, bound to its top.
// Depends on srtd_pkg.
`default_nettype none

module srtd_check (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         empty,
  input wire logic                         pop,
  input wire logic [srtd_pkg::STAT_W-1:0]  out_status,
  input wire logic [srtd_pkg::INDEX_W-1:0] out_run_first,
  input wire logic [srtd_pkg::LEN_W-1:0]   out_run_len,
  input wire logic                         out_run_positive,
  input wire logic [srtd_pkg::SUM_W-1:0]   out_run_sum
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status == srtd_pkg::ST_FOUND || out_status == srtd_pkg::ST_TOO_FEW
                || out_status == srtd_pkg::ST_NONE))
    else $error("undefined status code");

  a_no_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != srtd_pkg::ST_FOUND) |->
      (out_run_first == '0 && out_run_len == '0 && !out_run_positive && out_run_sum == '0))
    else $error("run fields set without a found run");

  a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == srtd_pkg::ST_FOUND) |-> (out_run_len != '0))
    else $error("found run has zero length");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_status) && $stable(out_run_sum)
                          && $stable(out_run_len) && $stable(out_run_first)))
    else $error("waiting result changed");

endmodule

bind signed_run_transient_detector srtd_check u_check (.*);

`default_nettype wire
